### design/bcd_clock_time_setter_unit_macros.svh
// Assertion macros for the BCD clock time setter.
// Used by bcd_clock_time_setter_unit; expects a clk and rst_n in scope.
`ifndef BCD_CLOCK_TIME_SETTER_UNIT_MACROS_SVH
`define BCD_CLOCK_TIME_SETTER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BCTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcts: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define BCTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcts: next-cycle check failed");

`endif

### design/bcts_pkg.sv
// Package for the BCD clock time setter: button codes, field limits,
// presets, the result record type and the BCD field normalizer. No dependencies.
package bcts_pkg;

  // Raw pull-up button patterns
  localparam logic [7:0] BTN_ADD   = 8'h1E;
  localparam logic [7:0] BTN_LEFT  = 8'h1D;
  localparam logic [7:0] BTN_RIGHT = 8'h1B;
  localparam logic [7:0] BTN_START = 8'h17;
  localparam logic [7:0] BTN_DONE  = 8'h0F;

  // Field selector codes
  localparam logic [7:0] SEL_SEC   = 8'd0;
  localparam logic [7:0] SEL_MIN   = 8'd1;
  localparam logic [7:0] SEL_HOUR  = 8'd2;
  localparam logic [7:0] SEL_GAP   = 8'd3;
  localparam logic [7:0] SEL_DAY   = 8'd4;
  localparam logic [7:0] SEL_MONTH = 8'd5;
  localparam logic [7:0] SEL_YEAR  = 8'd6;
  localparam logic [7:0] SEL_WRAP  = 8'd255;

  // Field limits (packed BCD)
  localparam logic [7:0] LIM_SEC   = 8'h59;
  localparam logic [7:0] LIM_MIN   = 8'h59;
  localparam logic [7:0] LIM_HOUR  = 8'h23;
  localparam logic [7:0] LIM_DAY   = 8'h31;
  localparam logic [7:0] LIM_MONTH = 8'h12;
  localparam logic [7:0] LIM_YEAR  = 8'h99;

  // Preset on start: 23:59:55 31/12/22
  localparam logic [7:0] PRE_SEC   = 8'h55;
  localparam logic [7:0] PRE_MIN   = 8'h59;
  localparam logic [7:0] PRE_HOUR  = 8'h23;
  localparam logic [7:0] PRE_DAY   = 8'h31;
  localparam logic [7:0] PRE_MONTH = 8'h12;
  localparam logic [7:0] PRE_YEAR  = 8'h22;

  localparam logic [3:0] BCD_MAX_DIGIT = 4'd9;

  typedef struct packed {
    logic [7:0] seconds;
    logic [7:0] minutes;
    logic [7:0] hours;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
    logic [7:0] field_select;
    logic       setting_active;
    logic       commit;
  } res_t;

  // Above limit -> zero; low digit past nine -> carry into tens, low digit zero.
  function automatic logic [7:0] norm_field(input logic [7:0] v, input logic [7:0] limit);
    logic [7:0] res;
    begin
      if (v > limit) begin
        res = 8'h00;
      end else if (v[3:0] > BCD_MAX_DIGIT) begin
        res = {v[7:4] + 4'd1, 4'd0};
      end else begin
        res = v;
      end
      return res;
    end
  endfunction

endpackage

### design/bcd_clock_time_setter_unit.sv
// Top level of the BCD clock time setter: state update, result register and
// skid stage. Depends on bcts_pkg and bcd_clock_time_setter_unit_macros.svh.
//
// Takes one transaction per clock while in_ready is high: a button event or a
// time load from the RTC (ignored while setting). The state update is a single
// level of decode, one 8-bit increment and per-field BCD compares, written at
// the accepting edge; its result goes to the result register, or to the skid
// stage while an earlier result waits. The one-entry skid stage keeps in_ready
// high while one finished result waits on out_ready; in_ready drops only when
// both are full. Sustained rate is one transaction per cycle with out_ready high.
`include "bcd_clock_time_setter_unit_macros.svh"

module bcd_clock_time_setter_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_command,
  input  logic [7:0] in_button_pattern,
  input  logic [7:0] in_load_seconds,
  input  logic [7:0] in_load_minutes,
  input  logic [7:0] in_load_hours,
  input  logic [7:0] in_load_day,
  input  logic [7:0] in_load_month,
  input  logic [7:0] in_load_year,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_seconds,
  output logic [7:0] out_minutes,
  output logic [7:0] out_hours,
  output logic [7:0] out_day,
  output logic [7:0] out_month,
  output logic [7:0] out_year,
  output logic [7:0] out_field_select,
  output logic       out_setting_active,
  output logic       out_commit
);

  // Clock state
  logic [7:0] sec_r, min_r, hour_r, day_r, month_r, year_r, sel_r;
  logic       setting_r;
  logic [7:0] sec_nxt, min_nxt, hour_nxt, day_nxt, month_nxt, year_nxt, sel_nxt;
  logic       setting_nxt;
  logic       commit_nxt;

  // Output buffering
  bcts_pkg::res_t res_new;
  bcts_pkg::res_t out_r, out_nxt;
  bcts_pkg::res_t skid_r, skid_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           skid_valid_r, skid_valid_nxt;

  logic in_take;
  logic out_take;
  logic out_setting_seen;

  assign in_ready = !skid_valid_r;
  assign in_take  = in_valid && in_ready;
  assign out_take = out_valid_r && out_ready;

  // Next state for one transaction
  always_comb begin
    logic [7:0] s, m, h, d, mo, y, sl;
    logic       set_f, cm;
    s  = sec_r;
    m  = min_r;
    h  = hour_r;
    d  = day_r;
    mo = month_r;
    y  = year_r;
    sl = sel_r;
    set_f = setting_r;
    cm = 1'b0;

    if (in_command) begin
      if (!setting_r) begin
        s  = in_load_seconds;
        m  = in_load_minutes;
        h  = in_load_hours;
        d  = in_load_day;
        mo = in_load_month;
        y  = in_load_year;
      end
    end else begin
      case (in_button_pattern)
        bcts_pkg::BTN_ADD: begin
          case (sel_r)
            bcts_pkg::SEL_SEC:   s  = s + 8'd1;
            bcts_pkg::SEL_MIN:   m  = m + 8'd1;
            bcts_pkg::SEL_HOUR:  h  = h + 8'd1;
            bcts_pkg::SEL_GAP:   sl = bcts_pkg::SEL_DAY;
            bcts_pkg::SEL_DAY:   d  = d + 8'd1;
            bcts_pkg::SEL_MONTH: mo = mo + 8'd1;
            bcts_pkg::SEL_YEAR:  y  = y + 8'd1;
            default: ;
          endcase
        end
        bcts_pkg::BTN_LEFT:  sl = sl + 8'd1;
        bcts_pkg::BTN_RIGHT: sl = sl - 8'd1;
        bcts_pkg::BTN_START: begin
          set_f = 1'b1;
          sl = bcts_pkg::SEL_SEC;
          s  = bcts_pkg::PRE_SEC;
          m  = bcts_pkg::PRE_MIN;
          h  = bcts_pkg::PRE_HOUR;
          d  = bcts_pkg::PRE_DAY;
          mo = bcts_pkg::PRE_MONTH;
          y  = bcts_pkg::PRE_YEAR;
        end
        bcts_pkg::BTN_DONE: cm = setting_r;
        default: ;
      endcase
    end

    // Normalize after every transaction while setting
    if (set_f) begin
      if (sl == bcts_pkg::SEL_WRAP) begin
        sl = bcts_pkg::SEL_YEAR;
      end else if (sl > bcts_pkg::SEL_YEAR) begin
        sl = bcts_pkg::SEL_SEC;
      end
      s  = bcts_pkg::norm_field(s,  bcts_pkg::LIM_SEC);
      m  = bcts_pkg::norm_field(m,  bcts_pkg::LIM_MIN);
      h  = bcts_pkg::norm_field(h,  bcts_pkg::LIM_HOUR);
      d  = bcts_pkg::norm_field(d,  bcts_pkg::LIM_DAY);
      mo = bcts_pkg::norm_field(mo, bcts_pkg::LIM_MONTH);
      y  = bcts_pkg::norm_field(y,  bcts_pkg::LIM_YEAR);
      if (cm) begin
        set_f = 1'b0;
      end
    end

    sec_nxt     = s;
    min_nxt     = m;
    hour_nxt    = h;
    day_nxt     = d;
    month_nxt   = mo;
    year_nxt    = y;
    sel_nxt     = sl;
    setting_nxt = set_f;
    commit_nxt  = cm;
  end

  always_comb begin
    res_new.seconds        = sec_nxt;
    res_new.minutes        = min_nxt;
    res_new.hours          = hour_nxt;
    res_new.day            = day_nxt;
    res_new.month          = month_nxt;
    res_new.year           = year_nxt;
    res_new.field_select   = sel_nxt;
    res_new.setting_active = setting_nxt;
    res_new.commit         = commit_nxt;
  end

  // Result register and skid stage
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_take) begin
      if (skid_valid_r) begin
        // advance the waiting result; a new transaction takes the skid slot
        out_nxt        = skid_r;
        skid_valid_nxt = in_take;
        if (in_take) begin
          skid_nxt = res_new;
        end
      end else begin
        out_valid_nxt = in_take;
        if (in_take) begin
          out_nxt = res_new;
        end
      end
    end else if (in_take) begin
      if (!out_valid_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = res_new;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = res_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r        <= 8'h00;
      min_r        <= 8'h00;
      hour_r       <= 8'h00;
      day_r        <= 8'h00;
      month_r      <= 8'h00;
      year_r       <= 8'h00;
      sel_r        <= 8'h00;
      setting_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        sec_r     <= sec_nxt;
        min_r     <= min_nxt;
        hour_r    <= hour_nxt;
        day_r     <= day_nxt;
        month_r   <= month_nxt;
        year_r    <= year_nxt;
        sel_r     <= sel_nxt;
        setting_r <= setting_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_seconds        = out_r.seconds;
  assign out_minutes        = out_r.minutes;
  assign out_hours          = out_r.hours;
  assign out_day            = out_r.day;
  assign out_month          = out_r.month;
  assign out_year           = out_r.year;
  assign out_field_select   = out_r.field_select;
  assign out_setting_active = out_r.setting_active;
  assign out_commit         = out_r.commit;

  assign out_setting_seen = out_valid_r && out_r.setting_active;

  `BCTS_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r)
  `BCTS_ASSERT_NOW(a_commit_ends_setting, out_valid_r && out_r.commit, !out_r.setting_active)
  `BCTS_ASSERT_NOW(a_sel_in_range, out_setting_seen, out_r.field_select <= bcts_pkg::SEL_YEAR)
  `BCTS_ASSERT_NOW(a_sec_in_range, out_setting_seen, out_r.seconds <= bcts_pkg::LIM_SEC)
  `BCTS_ASSERT_NOW(a_hour_in_range, out_setting_seen, out_r.hours <= bcts_pkg::LIM_HOUR)
  `BCTS_ASSERT_NEXT(a_state_holds_idle, !in_take, $stable(sel_r) && $stable(setting_r))

endmodule
